>>> design/mlvpg_pkg.sv
// ----------------------------------------------------------------------------
// mlvpg_pkg: shared types and constants for the latency-vote gating control
// field widths, operation and decision codes, register indexes and the
// status bundle of the remainder unit
// ----------------------------------------------------------------------------
package mlvpg_pkg;

    // fixed field widths
    localparam int OP_W      = 1;
    localparam int NODE_IN_W = 6;
    localparam int LAT_W     = 16;
    localparam int DEC_W     = 2;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 40;
    localparam int COUNT_W   = 24;
    localparam int VOTE_W    = 6;
    localparam int PROD_W    = CFG_W + COUNT_W;
    localparam int STEP_W    = $clog2(CNT_W);

    // saturation limits of the vote tally
    localparam logic signed [VOTE_W-1:0] VOTE_MAX = {1'b0, {(VOTE_W-1){1'b1}}};
    localparam logic signed [VOTE_W-1:0] VOTE_MIN = {1'b1, {(VOTE_W-1){1'b0}}};

    // input operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK   = 1'b1;

    // decision codes
    localparam logic [DEC_W-1:0] DEC_NONE    = 2'd0;
    localparam logic [DEC_W-1:0] DEC_AGGRESS = 2'd1;
    localparam logic [DEC_W-1:0] DEC_REGRESS = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GATING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd3;

    // per-node accumulator entry
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } acc_entry_t;

    // remainder unit status
    typedef struct packed {
        logic busy;
        logic done;
    } mod_status_t;

endpackage

>>> design/mlvpg_if.sv
// ----------------------------------------------------------------------------
// mlvpg channel interfaces
// valid/ready channels for input items and for gating decisions
// ----------------------------------------------------------------------------
interface mlvpg_in_if;
    logic                             valid;
    logic                             ready;
    logic [mlvpg_pkg::OP_W-1:0]       op;
    logic [mlvpg_pkg::NODE_IN_W-1:0]  sample_node;
    logic [mlvpg_pkg::LAT_W-1:0]      sample_latency;

    modport source (output valid, output op, output sample_node,
                    output sample_latency, input ready);
    modport sink   (input valid, input op, input sample_node,
                    input sample_latency, output ready);
endinterface

interface mlvpg_out_if;
    logic                             valid;
    logic                             ready;
    logic [mlvpg_pkg::NODE_IN_W-1:0]  target_node;
    logic [mlvpg_pkg::DEC_W-1:0]      decision;
    logic                             last_decision;

    modport source (output valid, output target_node, output decision,
                    output last_decision, input ready);
    modport sink   (input valid, input target_node, input decision,
                    input last_decision, output ready);
endinterface

>>> design/mlvpg_mod_unit.sv
// ----------------------------------------------------------------------------
// mlvpg_mod_unit: iterative remainder
// restoring remainder of the monitor counter by the epoch, one bit a cycle
// ----------------------------------------------------------------------------
module mlvpg_mod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mlvpg_pkg::CNT_W-1:0]   dividend,
    input  logic [mlvpg_pkg::CFG_W-1:0]   divisor,
    output logic [mlvpg_pkg::CFG_W-1:0]   remainder,
    output mlvpg_pkg::mod_status_t        status
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [mlvpg_pkg::STEP_W-1:0]  step_reg;
    logic [mlvpg_pkg::CNT_W-1:0]   quo_reg;
    logic [mlvpg_pkg::CFG_W-1:0]   rem_reg;
    logic [mlvpg_pkg::CFG_W:0]     trial;
    logic [mlvpg_pkg::CFG_W:0]     trial_sub;

    // one restoring step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[mlvpg_pkg::CNT_W-1]};
        trial_sub = trial - {1'b0, divisor};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == mlvpg_pkg::STEP_W'(mlvpg_pkg::CNT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[mlvpg_pkg::CNT_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_reg <= trial_sub[mlvpg_pkg::CFG_W-1:0];
            else
                rem_reg <= trial[mlvpg_pkg::CFG_W-1:0];
        end
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> design/mesh_latency_vote_power_gate_ctl.sv
// ----------------------------------------------------------------------------
// mesh_latency_vote_power_gate_ctl: latency-vote power-gating controller
// per-node latency accumulation, row/column vote sweeps and gating decisions
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items: op sample adds sample_latency to the sum and count of
//   sample_node, op tick advances the monitor counter and may sweep or decide.
//   out_ch carries one decision per node on a deciding tick, in node order,
//   last_decision set on the highest node. cfg_we/cfg_index/cfg_data write the
//   four control registers; the user must write them only while the block is
//   idle, which is not enforced. A sample passes accept, memory read and write
//   back; a tick with no sweep, accept and the tick check. A sweeping tick
//   takes the 2*MESH_RADIX-1 nodes of the swept row and column through read,
//   low multiply, high multiply and vote, sharing the single multiplier and
//   accumulator memory port. The first tick after an epoch_length write waits
//   for the bit-serial remainder unit if the epoch is nonzero. A deciding tick
//   loads MESH_RADIX*MESH_RADIX results into the output register, one per cycle
//   while out_ch.ready is high; a stalled receiver holds the decision walk.
//   After the last result is loaded the next item is taken.
//   Reset clears control state, votes and the per-node valid bits, so all
//   sums and counts read as zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mesh_latency_vote_power_gate_ctl #(
    parameter int MESH_RADIX = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mlvpg_in_if.sink                          in_ch,
    mlvpg_out_if.source                       out_ch,
    input  logic                              cfg_we,
    input  logic [mlvpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlvpg_pkg::CFG_W-1:0]       cfg_data
);

    localparam int NODE_COUNT = MESH_RADIX * MESH_RADIX;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int RC_W       = $clog2(MESH_RADIX);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ACC_RD = 10'b0000000010,
        S_ACC_WR = 10'b0000000100,
        S_MOD    = 10'b0000001000,
        S_TICK   = 10'b0000010000,
        S_RD     = 10'b0000100000,
        S_MUL_LO = 10'b0001000000,
        S_MUL_HI = 10'b0010000000,
        S_VOTE   = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    // control registers
    state_t                            state_reg, state_next;
    logic                              gating_reg;
    logic [mlvpg_pkg::CFG_W-1:0]       epoch_reg;
    logic [mlvpg_pkg::CFG_W-1:0]       low_reg;
    logic [mlvpg_pkg::CFG_W-1:0]       high_reg;
    logic [mlvpg_pkg::CNT_W-1:0]       counter_reg, counter_next;
    logic [mlvpg_pkg::CFG_W-1:0]       turn_reg, turn_next;
    logic                              stale_reg, stale_next;
    logic [RC_W-1:0]                   row_reg, row_next;
    logic [RC_W-1:0]                   col_reg, col_next;
    logic [NODE_W-1:0]                 emit_reg, emit_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              valid_reg [NODE_COUNT];
    logic                              valid_next [NODE_COUNT];
    logic signed [mlvpg_pkg::VOTE_W-1:0] vote_reg [NODE_COUNT];
    logic signed [mlvpg_pkg::VOTE_W-1:0] vote_next [NODE_COUNT];

    // payload registers
    logic [mlvpg_pkg::NODE_IN_W-1:0]   item_node_reg;
    logic [mlvpg_pkg::LAT_W-1:0]       item_lat_reg;
    mlvpg_pkg::acc_entry_t             rd_data_reg;
    logic                              rd_valid_reg;
    logic [mlvpg_pkg::PROD_W-1:0]      prod_reg;
    logic                              lt_reg;
    logic [mlvpg_pkg::NODE_IN_W-1:0]   out_node_reg;
    logic [mlvpg_pkg::DEC_W-1:0]       out_dec_reg;
    logic                              out_last_reg;

    // accumulator memory
    mlvpg_pkg::acc_entry_t             acc_mem [NODE_COUNT];

    // internal signals
    logic                              in_fire;
    logic                              cfg_epoch_wr;
    logic                              mod_start;
    logic [mlvpg_pkg::CFG_W-1:0]       mod_rem;
    mlvpg_pkg::mod_status_t            mod_st;
    logic                              acc_we;
    logic                              clear_node;
    logic                              clear_votes;
    logic                              out_load;
    logic                              tick_finish;
    logic                              emit_last;
    logic                              sweep_ok;
    logic [RC_W-1:0]                   turn_rc;
    logic [NODE_W-1:0]                 cur_node;
    logic [NODE_W-1:0]                 item_node;
    logic [NODE_W-1:0]                 rd_addr;
    logic [mlvpg_pkg::SUM_W-1:0]       sum_eff;
    logic [mlvpg_pkg::COUNT_W-1:0]     count_eff;
    logic [mlvpg_pkg::SUM_W:0]         sum_add;
    mlvpg_pkg::acc_entry_t             acc_wdata;
    logic [mlvpg_pkg::PROD_W-1:0]      scaled;
    logic [mlvpg_pkg::CFG_W-1:0]       mul_a;
    logic [mlvpg_pkg::PROD_W-1:0]      mul_prod;
    logic                              vote_up;
    logic                              vote_dn;
    logic                              in_row;
    logic                              in_col;
    logic [mlvpg_pkg::DEC_W-1:0]       emit_dec;
    logic signed [mlvpg_pkg::VOTE_W-1:0] emit_vote;

    // handshake
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_epoch_wr = cfg_we && (cfg_index == mlvpg_pkg::CFG_EPOCH);

    // remainder of counter by epoch after an epoch change
    mlvpg_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (counter_reg),
        .divisor   (epoch_reg),
        .remainder (mod_rem),
        .status    (mod_st)
    );

    // node under sweep and read address
    assign turn_rc   = turn_reg[RC_W-1:0];
    assign cur_node  = NODE_W'(int'(row_reg) * MESH_RADIX + int'(col_reg));
    assign item_node = item_node_reg[NODE_W-1:0];
    assign rd_addr   = (state_reg == S_ACC_RD) ? item_node : cur_node;
    assign in_row    = (row_reg == turn_rc);
    assign in_col    = (col_reg == turn_rc);

    // entry as read, invalid entries read as zero
    assign sum_eff   = rd_valid_reg ? rd_data_reg.sum : '0;
    assign count_eff = rd_valid_reg ? rd_data_reg.count : '0;

    // saturating accumulate
    always_comb
    begin
        sum_add = {1'b0, sum_eff} + (mlvpg_pkg::SUM_W+1)'(item_lat_reg);
        acc_wdata.sum = sum_add[mlvpg_pkg::SUM_W] ? {mlvpg_pkg::SUM_W{1'b1}}
                                                  : sum_add[mlvpg_pkg::SUM_W-1:0];
        acc_wdata.count = (&count_eff) ? count_eff : count_eff + 1'b1;
    end

    // shared multiplier: watermark times count
    assign mul_a    = (state_reg == S_MUL_HI) ? high_reg : low_reg;
    assign mul_prod = mlvpg_pkg::PROD_W'(mul_a) * mlvpg_pkg::PROD_W'(count_eff);
    assign scaled   = {sum_eff, 4'b0000};
    assign vote_up  = lt_reg;
    assign vote_dn  = !lt_reg && (scaled > prod_reg);

    // sweep enable
    assign sweep_ok = gating_reg && (epoch_reg != '0)
                      && (counter_reg >= mlvpg_pkg::CNT_W'(epoch_reg));

    // decision for the node being emitted
    assign emit_vote = vote_reg[emit_reg];
    assign emit_last = (emit_reg == NODE_W'(NODE_COUNT - 1));
    always_comb
    begin
        emit_dec = mlvpg_pkg::DEC_NONE;
        if (int'(emit_reg) < NODE_COUNT - MESH_RADIX)
        begin
            if (emit_vote > 0)
                emit_dec = mlvpg_pkg::DEC_AGGRESS;
            else if (emit_vote < 0)
                emit_dec = mlvpg_pkg::DEC_REGRESS;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        turn_next      = turn_reg;
        stale_next     = stale_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        emit_next      = emit_reg;
        mod_start      = 1'b0;
        acc_we         = 1'b0;
        clear_node     = 1'b0;
        clear_votes    = 1'b0;
        out_load       = 1'b0;
        tick_finish    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.op == mlvpg_pkg::OP_TICK)
                    begin
                        if (stale_reg && (epoch_reg != '0))
                        begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                        else
                            state_next = S_TICK;
                    end
                    else if (int'(in_ch.sample_node) < NODE_COUNT)
                        state_next = S_ACC_RD;
                end
            end
            S_ACC_RD:
                state_next = S_ACC_WR;
            S_ACC_WR:
            begin
                acc_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_MOD:
            begin
                if (mod_st.done)
                begin
                    turn_next  = mod_rem;
                    stale_next = 1'b0;
                    state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                if (sweep_ok && (turn_reg < mlvpg_pkg::CFG_W'(MESH_RADIX)))
                begin
                    row_next   = '0;
                    col_next   = (turn_reg == '0) ? '0 : turn_rc;
                    state_next = S_RD;
                end
                else if (sweep_ok && (turn_reg == mlvpg_pkg::CFG_W'(MESH_RADIX)))
                begin
                    emit_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    tick_finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_RD:
                state_next = S_MUL_LO;
            S_MUL_LO:
                state_next = S_MUL_HI;
            S_MUL_HI:
                state_next = S_VOTE;
            S_VOTE:
            begin
                clear_node = (count_eff != '0);
                state_next = S_RD;
                // walk the swept column above, the row, then the column below
                if (in_row)
                begin
                    if (col_reg != RC_W'(MESH_RADIX - 1))
                        col_next = col_reg + 1'b1;
                    else if (row_reg == RC_W'(MESH_RADIX - 1))
                    begin
                        tick_finish = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        col_next = turn_rc;
                    end
                end
                else if (row_reg == RC_W'(MESH_RADIX - 1))
                begin
                    tick_finish = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    if (row_reg + 1'b1 == turn_rc)
                        col_next = '0;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load = 1'b1;
                    if (emit_last)
                    begin
                        clear_votes  = 1'b1;
                        counter_next = mlvpg_pkg::CNT_W'(1);
                        turn_next    = mlvpg_pkg::CFG_W'(1);
                        state_next   = S_IDLE;
                    end
                    else
                        emit_next = emit_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // counter advance and its running remainder
        if (tick_finish)
        begin
            counter_next = counter_reg + 1'b1;
            if (counter_next == '0)
                turn_next = '0;
            else if ({1'b0, turn_reg} + 1'b1 == {1'b0, epoch_reg})
                turn_next = '0;
            else
                turn_next = turn_reg + 1'b1;
        end

        if (cfg_epoch_wr)
            stale_next = 1'b1;
    end

    // output register
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // per-node valid bits
    always_comb
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            valid_next[i] = valid_reg[i];
            if (acc_we && (item_node == NODE_W'(i)))
                valid_next[i] = 1'b1;
            if (clear_node && (cur_node == NODE_W'(i)))
                valid_next[i] = 1'b0;
        end
    end

    // vote cells, one saturating adder per node
    for (genvar g = 0; g < NODE_COUNT; g++)
    begin : g_vote
        localparam int TR = g / MESH_RADIX;
        localparam int TC = g % MESH_RADIX;
        logic hit;

        assign hit = (in_row && (row_reg == RC_W'(TR)))
                     || (in_col && (col_reg == RC_W'(TC)));

        always_comb
        begin
            vote_next[g] = vote_reg[g];
            if (clear_votes)
                vote_next[g] = '0;
            else if (clear_node && hit)
            begin
                if (vote_up && (vote_reg[g] != mlvpg_pkg::VOTE_MAX))
                    vote_next[g] = vote_reg[g] + mlvpg_pkg::VOTE_W'(1);
                else if (vote_dn && (vote_reg[g] != mlvpg_pkg::VOTE_MIN))
                    vote_next[g] = vote_reg[g] - mlvpg_pkg::VOTE_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gating_reg    <= 1'b0;
            epoch_reg     <= mlvpg_pkg::CFG_W'(10000);
            low_reg       <= mlvpg_pkg::CFG_W'(320);
            high_reg      <= mlvpg_pkg::CFG_W'(960);
            counter_reg   <= '0;
            turn_reg      <= '0;
            stale_reg     <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                valid_reg[i] <= 1'b0;
                vote_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            turn_reg      <= turn_next;
            stale_reg     <= stale_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                valid_reg[i] <= valid_next[i];
                vote_reg[i]  <= vote_next[i];
            end
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    mlvpg_pkg::CFG_GATING: gating_reg <= cfg_data[0];
                    mlvpg_pkg::CFG_EPOCH:  epoch_reg  <= cfg_data;
                    mlvpg_pkg::CFG_LOW:    low_reg    <= cfg_data;
                    mlvpg_pkg::CFG_HIGH:   high_reg   <= cfg_data;
                    default:               gating_reg <= gating_reg;
                endcase
            end
        end
    end

    // item capture, memory port, multiplier and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_node_reg <= in_ch.sample_node;
            item_lat_reg  <= in_ch.sample_latency;
        end
        rd_data_reg  <= acc_mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
        if (acc_we)
            acc_mem[item_node] <= acc_wdata;
        if ((state_reg == S_MUL_LO) || (state_reg == S_MUL_HI))
            prod_reg <= mul_prod;
        if (state_reg == S_MUL_HI)
            lt_reg <= (scaled < prod_reg);
        if (out_load)
        begin
            out_node_reg <= mlvpg_pkg::NODE_IN_W'(emit_reg);
            out_dec_reg  <= emit_dec;
            out_last_reg <= emit_last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.target_node   = out_node_reg;
    assign out_ch.decision      = out_dec_reg;
    assign out_ch.last_decision = out_last_reg;

    // checks
    a_vote_turn_in_mesh: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VOTE) |-> (turn_reg < mlvpg_pkg::CFG_W'(MESH_RADIX)))
        else $error("vote step with turn outside the mesh");

    a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_st.done |-> (state_reg == S_MOD))
        else $error("remainder done outside its wait state");

    a_decide_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_last) |=> ((counter_reg == mlvpg_pkg::CNT_W'(1))
                                     && (state_reg == S_IDLE)))
        else $error("counter not restarted after the final decision");

    a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !mod_st.busy)
        else $error("input ready while remainder unit busy");

endmodule

>>> tb/sv/tb_mesh_latency_vote_power_gate_ctl.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mesh_latency_vote_power_gate_ctl: self-checking bench for the gating control
// a queue-fed driver offers latency samples and ticks, a bit-accurate predictor
// of the per-node sums, row/column votes and decisions builds the expected
// decision stream, and a monitor checks every decision transfer against it
// while both channel sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_mesh_latency_vote_power_gate_ctl;

    localparam int RADIX          = 4;
    localparam int NODES          = RADIX * RADIX;
    localparam int CLK_PERIOD_NS  = 12;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 120;
    localparam int RX_HOLD_CYCLES = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    localparam logic [mlvpg_pkg::CFG_W-1:0]   CFG_MAX    = {mlvpg_pkg::CFG_W{1'b1}};
    localparam logic [mlvpg_pkg::SUM_W-1:0]   SUM_FULL   = {mlvpg_pkg::SUM_W{1'b1}};
    localparam logic [mlvpg_pkg::COUNT_W-1:0] COUNT_FULL = {mlvpg_pkg::COUNT_W{1'b1}};

    typedef struct packed {
        logic [mlvpg_pkg::OP_W-1:0]      op;
        logic [mlvpg_pkg::NODE_IN_W-1:0] node;
        logic [mlvpg_pkg::LAT_W-1:0]     lat;
    } gate_item_t;

    typedef struct packed {
        logic [mlvpg_pkg::NODE_IN_W-1:0] node;
        logic [mlvpg_pkg::DEC_W-1:0]     dec;
        logic                            last;
    } gate_decision_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [mlvpg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mlvpg_pkg::CFG_W-1:0]     cfg_data;

    mlvpg_in_if  in_ch ();
    mlvpg_out_if out_ch ();

    mesh_latency_vote_power_gate_ctl #(
        .MESH_RADIX (RADIX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted controller state and registers
    logic [mlvpg_pkg::SUM_W-1:0]         lat_sum   [NODES];
    logic [mlvpg_pkg::COUNT_W-1:0]       lat_count [NODES];
    logic signed [mlvpg_pkg::VOTE_W-1:0] tally     [NODES];
    logic [mlvpg_pkg::CNT_W-1:0]         tick_count;
    logic                                gate_on;
    logic [mlvpg_pkg::CFG_W-1:0]         epoch_len;
    logic [mlvpg_pkg::CFG_W-1:0]         low_q4;
    logic [mlvpg_pkg::CFG_W-1:0]         high_q4;

    gate_item_t     items_to_send [$];
    gate_decision_t decisions_due [$];

    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic rx_hold_req  = 1'b0;
    int   rx_hold_left = 0;
    int   mismatches   = 0;

    // clock
    always
    begin
        #(CLK_PERIOD_NS / 2) clk = 1'b1;
        #(CLK_PERIOD_NS / 2) clk = 1'b0;
    end

    // average against watermarks: +1 below low, -1 above high
    function automatic int node_vote(int n);
        logic [63:0] scaled;
        logic [63:0] low_lim;
        logic [63:0] high_lim;
        scaled   = 64'(lat_sum[n]) << 4;
        low_lim  = 64'(low_q4) * 64'(lat_count[n]);
        high_lim = 64'(high_q4) * 64'(lat_count[n]);
        if (scaled < low_lim)
            return 1;
        if (scaled > high_lim)
            return -1;
        return 0;
    endfunction

    // saturating tally update
    function automatic void add_vote(int n, int v);
        int t;
        t = int'(tally[n]) + v;
        if (t > int'(mlvpg_pkg::VOTE_MAX))
            t = int'(mlvpg_pkg::VOTE_MAX);
        if (t < int'(mlvpg_pkg::VOTE_MIN))
            t = int'(mlvpg_pkg::VOTE_MIN);
        tally[n] = mlvpg_pkg::VOTE_W'(t);
    endfunction

    // row and column sweep, in node order, since saturation makes order matter
    function automatic void sweep_lines(logic [mlvpg_pkg::CNT_W-1:0] turn);
        bit in_row;
        bit in_col;
        int n;
        int v;
        for (int row = 0; row < RADIX; row++)
        begin
            for (int col = 0; col < RADIX; col++)
            begin
                in_row = (mlvpg_pkg::CNT_W'(row) == turn);
                in_col = (mlvpg_pkg::CNT_W'(col) == turn);
                n      = row * RADIX + col;
                if ((in_row || in_col) && lat_count[n] != '0)
                begin
                    v = node_vote(n);
                    if (in_row)
                        for (int k = 0; k < RADIX; k++)
                            if (k != col)
                                add_vote(row * RADIX + k, v);
                    if (in_col)
                        for (int k = 0; k < RADIX; k++)
                            if (k != row)
                                add_vote(k * RADIX + col, v);
                    add_vote(n, v);
                    lat_sum[n]   = '0;
                    lat_count[n] = '0;
                end
            end
        end
    endfunction

    // one accepted item: accumulate a sample, or tick with sweep and decisions
    function automatic void step_gating_model(gate_item_t it);
        logic [mlvpg_pkg::SUM_W:0]   grown;
        logic [mlvpg_pkg::CNT_W-1:0] turn;
        gate_decision_t              d;
        int                          n;
        if (it.op == mlvpg_pkg::OP_SAMPLE)
        begin
            // samples to nodes outside the mesh are dropped
            if (int'(it.node) < NODES)
            begin
                n     = int'(it.node);
                grown = {1'b0, lat_sum[n]} + (mlvpg_pkg::SUM_W + 1)'(it.lat);
                lat_sum[n] = (grown > {1'b0, SUM_FULL}) ? SUM_FULL
                                                        : grown[mlvpg_pkg::SUM_W-1:0];
                if (lat_count[n] != COUNT_FULL)
                    lat_count[n] = lat_count[n] + 1'b1;
            end
        end
        else
        begin
            if (gate_on && epoch_len != '0 && tick_count >= mlvpg_pkg::CNT_W'(epoch_len))
            begin
                turn = tick_count % mlvpg_pkg::CNT_W'(epoch_len);
                sweep_lines(turn);
                if (turn == mlvpg_pkg::CNT_W'(RADIX))
                begin
                    for (n = 0; n < NODES; n++)
                    begin
                        d.node = mlvpg_pkg::NODE_IN_W'(n);
                        d.dec  = mlvpg_pkg::DEC_NONE;
                        // last row never gets a decision
                        if (n < NODES - RADIX)
                        begin
                            if (tally[n] > 0)
                                d.dec = mlvpg_pkg::DEC_AGGRESS;
                            else if (tally[n] < 0)
                                d.dec = mlvpg_pkg::DEC_REGRESS;
                        end
                        d.last   = (n == NODES - 1);
                        tally[n] = '0;
                        decisions_due.push_back(d);
                    end
                    tick_count = '0;
                end
            end
            tick_count = tick_count + 1'b1;
        end
    endfunction

    function automatic gate_item_t sample_item(int node, int lat);
        return '{mlvpg_pkg::OP_SAMPLE, mlvpg_pkg::NODE_IN_W'(node),
                 mlvpg_pkg::LAT_W'(lat)};
    endfunction

    // ticks carry random, unused payload
    function automatic gate_item_t tick_item();
        return '{mlvpg_pkg::OP_TICK, mlvpg_pkg::NODE_IN_W'($urandom_range(63)),
                 mlvpg_pkg::LAT_W'($urandom())};
    endfunction

    // random item, latencies clustered around the current watermarks
    function automatic gate_item_t random_item(int tick_pct);
        gate_item_t it;
        int         pick;
        int         base;
        if ($urandom_range(99) < tick_pct)
            return tick_item();
        it.op = mlvpg_pkg::OP_SAMPLE;
        if ($urandom_range(9) == 0)
            it.node = mlvpg_pkg::NODE_IN_W'($urandom_range(63, NODES));
        else
            it.node = mlvpg_pkg::NODE_IN_W'($urandom_range(NODES - 1));
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            base = (pick < 35) ? int'(low_q4 >> 4) : int'(high_q4 >> 4);
            base = base + int'($urandom_range(4)) - 2;
            if (base < 0)
                base = 0;
            if (base > 65535)
                base = 65535;
            it.lat = mlvpg_pkg::LAT_W'(base);
        end
        else if (pick < 78)
            it.lat = '0;
        else if (pick < 86)
            it.lat = '1;
        else
            it.lat = mlvpg_pkg::LAT_W'($urandom());
        return it;
    endfunction

    // dropped samples do not count toward the item total
    task automatic queue_random_items(int count, int tick_pct);
        gate_item_t it;
        int         taken;
        taken = 0;
        while (taken < count)
        begin
            it = random_item(tick_pct);
            items_to_send.push_back(it);
            if (!(it.op == mlvpg_pkg::OP_SAMPLE && int'(it.node) >= NODES))
                taken++;
        end
    endtask

    // all items accepted and every predicted decision seen
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_to_send.size() != 0 || in_ch.valid || decisions_due.size() != 0);
    endtask

    task automatic write_reg(logic [mlvpg_pkg::CFG_IDX_W-1:0] idx,
                             logic [mlvpg_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            mlvpg_pkg::CFG_GATING: gate_on   = val[0];
            mlvpg_pkg::CFG_EPOCH:  epoch_len = val;
            mlvpg_pkg::CFG_LOW:    low_q4    = val;
            mlvpg_pkg::CFG_HIGH:   high_q4   = val;
            default:    ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // registers change only once the block has gone quiet
    task automatic configure(logic gate, logic [mlvpg_pkg::CFG_W-1:0] epoch,
                             logic [mlvpg_pkg::CFG_W-1:0] low,
                             logic [mlvpg_pkg::CFG_W-1:0] high);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(mlvpg_pkg::CFG_GATING, mlvpg_pkg::CFG_W'(gate));
        write_reg(mlvpg_pkg::CFG_EPOCH, epoch);
        write_reg(mlvpg_pkg::CFG_LOW, low);
        write_reg(mlvpg_pkg::CFG_HIGH, high);
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        @(negedge clk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // input driver: offer the next pending item, hold it until the transfer
    always @(posedge clk)
    begin : drive_items
        gate_item_t nxt;
        gate_item_t seen;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                seen.op   = in_ch.op;
                seen.node = in_ch.sample_node;
                seen.lat  = in_ch.sample_latency;
                step_gating_model(seen);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = items_to_send[0];
                    items_to_send.delete(0);
                    in_ch.valid          <= 1'b1;
                    in_ch.op             <= nxt.op;
                    in_ch.sample_node    <= nxt.node;
                    in_ch.sample_latency <= nxt.lat;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin : count_rx_hold
        if (rx_hold_req)
            rx_hold_left <= RX_HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // decision monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin : check_decisions
        gate_decision_t got;
        gate_decision_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.node = out_ch.target_node;
            got.dec  = out_ch.decision;
            got.last = out_ch.last_decision;
            if (decisions_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected decision: node %0d dec %0d last %0b",
                             got.node, got.dec, got.last);
            end
            else
            begin
                want = decisions_due[0];
                decisions_due.delete(0);
                if (got.node !== want.node || got.dec !== want.dec || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("decision mismatch: expected node %0d dec %0d last %0b,",
                                 want.node, want.dec, want.last,
                                 " got node %0d dec %0d last %0b",
                                 got.node, got.dec, got.last);
                end
            end
        end
        out_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    initial
    begin : stimulus
        logic [mlvpg_pkg::CFG_W-1:0] lo_r;
        logic [mlvpg_pkg::CFG_W-1:0] hi_r;

        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.op             = mlvpg_pkg::OP_SAMPLE;
        in_ch.sample_node    = '0;
        in_ch.sample_latency = '0;
        out_ch.ready         = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = mlvpg_pkg::CFG_GATING;
        cfg_data             = '0;

        // predictor at its reset values
        gate_on    = 1'b0;
        epoch_len  = mlvpg_pkg::CFG_W'(10000);
        low_q4     = mlvpg_pkg::CFG_W'(320);
        high_q4    = mlvpg_pkg::CFG_W'(960);
        tick_count = '0;
        for (int n = 0; n < NODES; n++)
        begin
            lat_sum[n]   = '0;
            lat_count[n] = '0;
            tally[n]     = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: watermark edges, field extremes, absent nodes, one full epoch
        configure(1'b1, mlvpg_pkg::CFG_W'(5), mlvpg_pkg::CFG_W'(320),
                  mlvpg_pkg::CFG_W'(960));
        set_idling(0, 0);
        items_to_send.push_back(sample_item(0, 0));
        items_to_send.push_back(sample_item(15, 65535));
        items_to_send.push_back(sample_item(63, 1234));
        items_to_send.push_back(sample_item(16, 99));
        items_to_send.push_back(sample_item(5, 20));
        items_to_send.push_back(sample_item(10, 60));
        items_to_send.push_back(sample_item(6, 61));
        items_to_send.push_back(sample_item(9, 19));
        items_to_send.push_back(sample_item(12, 3));
        repeat (6) items_to_send.push_back(tick_item());
        items_to_send.push_back(sample_item(0, 100));
        repeat (4) items_to_send.push_back(tick_item());

        // random, no idling
        configure(1'b1, mlvpg_pkg::CFG_W'(6), mlvpg_pkg::CFG_W'(320),
                  mlvpg_pkg::CFG_W'(960));
        set_idling(0, 0);
        queue_random_items(40, 45);

        // random marks, sender mostly idle
        lo_r = mlvpg_pkg::CFG_W'($urandom_range(2000));
        hi_r = mlvpg_pkg::CFG_W'($urandom_range(2000));
        configure(1'b1, mlvpg_pkg::CFG_W'(5), lo_r, hi_r);
        set_idling(76, 0);
        queue_random_items(40, 45);

        // receiver holds off while the sender keeps offering, then a sender pause
        configure(1'b1, mlvpg_pkg::CFG_W'(8), mlvpg_pkg::CFG_W'(480),
                  mlvpg_pkg::CFG_W'(800));
        @(posedge clk);
        rx_hold_req <= 1'b1;
        @(posedge clk);
        rx_hold_req <= 1'b0;
        set_idling(0, 76);
        queue_random_items(30, 60);
        wait_drained();
        queue_random_items(30, 45);

        // widest watermark spread: nothing ever votes
        configure(1'b1, mlvpg_pkg::CFG_W'(7), '0, CFG_MAX);
        set_idling(18, 18);
        queue_random_items(30, 45);

        // short epoch: votes pile up toward the tally limits, never cleared
        configure(1'b1, mlvpg_pkg::CFG_W'(3), CFG_MAX, CFG_MAX);
        set_idling(0, 0);
        queue_random_items(110, 50);

        // zero marks vote down from the saturated tallies
        configure(1'b1, mlvpg_pkg::CFG_W'(9), '0, '0);
        set_idling(18, 18);
        queue_random_items(40, 45);

        // gating off: samples and counter still move
        configure(1'b0, mlvpg_pkg::CFG_W'(5), mlvpg_pkg::CFG_W'(320),
                  mlvpg_pkg::CFG_W'(960));
        set_idling(76, 0);
        queue_random_items(20, 45);

        // zero epoch never sweeps
        configure(1'b1, '0, mlvpg_pkg::CFG_W'(320), mlvpg_pkg::CFG_W'(960));
        set_idling(0, 76);
        queue_random_items(15, 45);

        // largest epoch is never reached here
        configure(1'b1, CFG_MAX, mlvpg_pkg::CFG_W'(320), mlvpg_pkg::CFG_W'(960));
        set_idling(0, 0);
        queue_random_items(15, 45);

        // epoch of one sweeps row and column zero on every tick
        lo_r = mlvpg_pkg::CFG_W'($urandom_range(2000));
        hi_r = mlvpg_pkg::CFG_W'($urandom_range(2000));
        configure(1'b1, mlvpg_pkg::CFG_W'(1), lo_r, hi_r);
        set_idling(18, 18);
        queue_random_items(20, 45);

        // back to deciding epochs with random marks
        lo_r = mlvpg_pkg::CFG_W'($urandom_range(2000));
        hi_r = mlvpg_pkg::CFG_W'($urandom_range(2000));
        configure(1'b1, mlvpg_pkg::CFG_W'(6), lo_r, hi_r);
        set_idling(0, 76);
        queue_random_items(40, 45);

        configure(1'b1, mlvpg_pkg::CFG_W'(12), mlvpg_pkg::CFG_W'(320),
                  mlvpg_pkg::CFG_W'(960));
        set_idling(76, 0);
        queue_random_items(25, 50);

        // drain and let the last item finish
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && decisions_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
